### rtl/core/iso_pht_pkg.sv
`timescale 1ns / 1ps

package iso_pht_pkg;

    localparam int MAX_PACKET_QUADLETS_DEF = 512;

    localparam logic [7:0]  FMT_CODE         = 8'h22;
    localparam logic [1:0]  TAG_ISO          = 2'd1;
    localparam logic [13:0] WRAP_LIMIT       = 14'd1000;
    localparam logic [8:0]  COUNT_MAX        = 9'd511;
    localparam logic [31:0] SECOND_TICKS     = 32'd24576000;
    localparam logic [24:0] STAMP_MASK       = 25'h1ffffff;

    // per-packet summary handed from the tracker to the timestamp stage
    typedef struct packed {
        logic        pkt_ok;
        logic [24:0] stamp;
        logic [6:0]  now_sec;
        logic [12:0] now_cyc;
        logic [8:0]  events;
    } pkt_sum_t;

endpackage

### rtl/core/iso_packet_header_timestamp_top.sv
`timescale 1ns / 1ps
// a packet's last quadlet and its result pass the input, summary and output registers in turn
// throughput: one quadlet per cycle unless stalled, set by a single tracker pass per quadlet
// one result per packet; input stalls only when two results are already queued
// reset: synchronous active-low aresetn clears the packet state and all valid flags
module iso_packet_header_timestamp_top
    import iso_pht_pkg::*;
#(
    parameter int MAX_PACKET_QUADLETS = MAX_PACKET_QUADLETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // quadlet [31:0], cycle_timer_now [63:32]
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,  // packet_tag [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // timestamp_ticks [31:0], event_count [40:32], zero [47:41]
    output logic        m_tlast,
    output logic        m_tuser   // status [0]
);

    logic        in_valid_reg;
    logic [31:0] quadlet_reg;
    logic [31:0] now_reg;
    logic        last_reg;
    logic [1:0]  tag_reg;
    logic        in_take;
    logic        sum_valid;
    logic        sum_ready;
    pkt_sum_t    sum;
    logic [31:0] ticks;
    logic [8:0]  events;

    assign s_tready = !in_valid_reg || in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            quadlet_reg <= s_tdata[31:0];
            now_reg     <= s_tdata[63:32];
            last_reg    <= s_tlast;
            tag_reg     <= s_tuser;
        end
    end

    iso_pht_track #(
        .MAX_PACKET_QUADLETS(MAX_PACKET_QUADLETS)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_quadlet (quadlet_reg),
        .in_last    (last_reg),
        .in_tag     (tag_reg),
        .in_now     (now_reg),
        .in_take    (in_take),
        .sum_valid  (sum_valid),
        .sum        (sum),
        .sum_ready  (sum_ready)
    );

    iso_pht_stamp u_stamp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sum_valid  (sum_valid),
        .sum        (sum),
        .sum_ready  (sum_ready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_ticks  (ticks),
        .out_events (events),
        .out_ready  (m_tready)
    );

    assign m_tdata = {7'd0, events, ticks};
    assign m_tlast = 1'b1;

endmodule

### rtl/core/iso_pht_track.sv
`timescale 1ns / 1ps

module iso_pht_track
    import iso_pht_pkg::*;
#(
    parameter int MAX_PACKET_QUADLETS = MAX_PACKET_QUADLETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [31:0] in_quadlet,
    input  logic        in_last,
    input  logic [1:0]  in_tag,
    input  logic [31:0] in_now,
    output logic        in_take,
    output logic        sum_valid,
    output pkt_sum_t    sum,
    input  logic        sum_ready
);

    localparam int QW = $clog2(MAX_PACKET_QUADLETS + 1);
    localparam logic [QW-1:0] IDX_MAX = QW'(MAX_PACKET_QUADLETS);

    logic [QW-1:0] idx_reg, idx_next;
    logic [7:0]    bsize_reg, bsize_next;
    logic          fmt_reg, fmt_next;
    logic [7:0]    pos_reg, pos_next;
    logic [24:0]   cand_reg, cand_next;
    logic [24:0]   commit_reg, commit_next;
    logic [8:0]    events_reg, events_next;
    logic          sum_valid_reg;
    pkt_sum_t      sum_reg, sum_next;
    logic          mid_ready;
    logic [7:0]    field;

    assign mid_ready = !sum_valid_reg || sum_ready;
    assign in_take   = in_valid && (!in_last || mid_ready);
    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign field     = in_quadlet[23:16];

    always_comb begin
        idx_next    = idx_reg;
        bsize_next  = bsize_reg;
        fmt_next    = fmt_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        commit_next = commit_reg;
        events_next = events_reg;
        if (idx_reg < IDX_MAX) begin
            if (idx_reg == '0) begin
                bsize_next = field;
            end else if (idx_reg == QW'(1)) begin
                fmt_next = (field == FMT_CODE);
            end else if (bsize_reg != '0) begin
                if (pos_reg == '0) begin
                    cand_next = in_quadlet[24:0] & STAMP_MASK;
                end
                if ({1'b0, pos_reg} + 9'd1 >= {1'b0, bsize_reg}) begin
                    commit_next = cand_next;
                    if (events_reg < COUNT_MAX) begin
                        events_next = events_reg + 9'd1;
                    end
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            idx_next = idx_reg + QW'(1);
        end
        sum_next.pkt_ok  = (idx_next > QW'(2)) && fmt_next && (in_tag == TAG_ISO) &&
                           (bsize_next != '0) && (events_next != '0);
        sum_next.stamp   = commit_next;
        sum_next.now_sec = in_now[31:25];
        sum_next.now_cyc = in_now[24:12];
        sum_next.events  = events_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            bsize_reg     <= '0;
            fmt_reg       <= 1'b0;
            pos_reg       <= '0;
            cand_reg      <= '0;
            commit_reg    <= '0;
            events_reg    <= '0;
            sum_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                if (in_last) begin
                    idx_reg    <= '0;
                    bsize_reg  <= '0;
                    fmt_reg    <= 1'b0;
                    pos_reg    <= '0;
                    cand_reg   <= '0;
                    commit_reg <= '0;
                    events_reg <= '0;
                end else begin
                    idx_reg    <= idx_next;
                    bsize_reg  <= bsize_next;
                    fmt_reg    <= fmt_next;
                    pos_reg    <= pos_next;
                    cand_reg   <= cand_next;
                    commit_reg <= commit_next;
                    events_reg <= events_next;
                end
            end
            if (in_take && in_last) begin
                sum_valid_reg <= 1'b1;
            end else if (sum_ready) begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && in_last) begin
            sum_reg <= sum_next;
        end
    end

endmodule

### rtl/core/iso_pht_stamp.sv
`timescale 1ns / 1ps

module iso_pht_stamp
    import iso_pht_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        sum_valid,
    input  pkt_sum_t    sum,
    output logic        sum_ready,
    output logic        out_valid,
    output logic        out_status,
    output logic [31:0] out_ticks,
    output logic [8:0]  out_events,
    input  logic        out_ready
);

    logic        out_valid_reg;
    logic        status_reg;
    logic [31:0] ticks_reg;
    logic [8:0]  events_reg;
    logic [12:0] s_cyc;
    logic [11:0] s_off;
    logic [24:0] cyc_ticks;
    logic [6:0]  sec_adj;
    logic [31:0] sec_ticks;
    logic [31:0] full_ticks;

    assign sum_ready  = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_ticks  = ticks_reg;
    assign out_events = events_reg;

    assign s_cyc = sum.stamp[24:12];
    assign s_off = sum.stamp[11:0];

    // cycles * 3072 + offset
    assign cyc_ticks = {1'b0, s_cyc, 11'd0} + {2'b0, s_cyc, 10'd0} + {13'd0, s_off};

    // seconds wrap at 128 either way
    always_comb begin
        sec_adj = sum.now_sec;
        if ({1'b0, s_cyc} > {1'b0, sum.now_cyc} + WRAP_LIMIT) begin
            sec_adj = sum.now_sec - 7'd1;
        end else if ({1'b0, sum.now_cyc} > {1'b0, s_cyc} + WRAP_LIMIT) begin
            sec_adj = sum.now_sec + 7'd1;
        end
    end

    assign sec_ticks  = 32'(32'(sec_adj) * SECOND_TICKS);
    assign full_ticks = 32'(cyc_ticks) + sec_ticks;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && sum_valid) begin
            status_reg <= !sum.pkt_ok;
            ticks_reg  <= sum.pkt_ok ? full_ticks : '0;
            events_reg <= sum.events;
        end
    end

endmodule
